// ===== rtl/ccc_pkg.sv =====
// Shared types and constants for the cache controller.
package ccc_pkg;

    localparam int LINES_DEF       = 8;
    localparam int BLOCK_WORDS_DEF = 4;
    localparam int MEM_BLOCKS_DEF  = 64;

    localparam int CMD_W   = 1;
    localparam int ADDR_W  = 8;
    localparam int DATA_W  = 32;
    localparam int LINE_W  = 3;
    localparam int BLOCK_W = 6;
    localparam int CNT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAPPING     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETS        = 2'd3;

    localparam logic [1:0] MAP_DIRECT = 2'd0;
    localparam logic [1:0] MAP_FULL   = 2'd1;
    localparam logic [1:0] MAP_SET    = 2'd2;

    localparam logic [1:0] POL_RANDOM = 2'd0;
    localparam logic [1:0] POL_FIFO   = 2'd1;
    localparam logic [1:0] POL_LFU    = 2'd2;
    localparam logic [1:0] POL_LRU    = 2'd3;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [15:0] LFSR_MASK = 16'hB400;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RANGE,
        ST_SCAN1,
        ST_SCAN2,
        ST_SCAN3,
        ST_PICK,
        ST_TOUCH,
        ST_WB_RD,
        ST_WB_WR,
        ST_FILL_RD,
        ST_FILL_WAIT,
        ST_FILL_WR,
        ST_WRITE,
        ST_CLEAR,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } ccc_state_t;

    // Result fields handed from the sequencer to the output register.
    typedef struct packed {
        logic              hit;
        logic [LINE_W-1:0] line_index;
        logic [BLOCK_W-1:0] block_number;
        logic              address_error;
    } ccc_result_t;

endpackage

// ===== rtl/ccc_ram.sv =====
// Generic RAM with one write port and one registered read port.
module ccc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/configurable_cache_controller_top.sv =====
// Top level of the configurable cache controller: sequencer, tags, counters and RAMs.
//
// A command is taken when start is high and busy is low; busy then stays high until
// the single result appears on the result ports with done high for one cycle. The
// receiver cannot stall results. One command takes a lookup scan over all LINES lines,
// up to three further counter scans over the candidate lines on a miss, and on a miss a
// write-back (if the line is valid) and a fill of BLOCK_WORDS words each through the
// RAMs. Random replacement replaces the counter scans by a remainder step. In set
// associative mode the set range is found by repeated subtraction. After reset the
// backing memory is cleared one word a cycle; busy is high during that pass.
// Configuration writes are taken at any time and must be made only while the block
// is idle.
module configurable_cache_controller_top #(
    parameter int LINES       = ccc_pkg::LINES_DEF,
    parameter int BLOCK_WORDS = ccc_pkg::BLOCK_WORDS_DEF,
    parameter int MEM_BLOCKS  = ccc_pkg::MEM_BLOCKS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ccc_pkg::CMD_W-1:0]         command,
    input  logic [ccc_pkg::ADDR_W-1:0]        word_address,
    input  logic signed [ccc_pkg::DATA_W-1:0] write_value,
    output logic                              done,
    output logic                              hit,
    output logic [ccc_pkg::LINE_W-1:0]        line_index,
    output logic [ccc_pkg::BLOCK_W-1:0]       block_number,
    output logic signed [ccc_pkg::DATA_W-1:0] data_word,
    output logic                              address_error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ccc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ccc_pkg::*;

    localparam int LW   = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int LC   = $clog2(LINES + 1);
    localparam int OW   = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int OC   = $clog2(BLOCK_WORDS + 1);
    localparam int MEM_WORDS = MEM_BLOCKS * BLOCK_WORDS;
    localparam int MW   = $clog2(MEM_WORDS);
    localparam int MC   = $clog2(MEM_WORDS + 1);
    localparam int BW   = (MEM_BLOCKS > 1) ? $clog2(MEM_BLOCKS) : 1;
    localparam int DW   = $clog2(LINES * BLOCK_WORDS);
    localparam int AW   = (ADDR_W > MW) ? ADDR_W : MW + 1;
    localparam int RW   = LC + 1;

    ccc_state_t state_reg, state_next;

    logic [1:0] map_reg, pol_reg;
    logic       wpol_reg;
    logic [3:0] sets_reg;

    logic [BW-1:0]    tag_reg [LINES];
    logic [LINES-1:0] valid_reg;
    logic [CNT_W-1:0] cnt_reg [LINES];
    logic             full_reg;
    logic [15:0]      lfsr_reg;

    logic             cmd_reg;
    logic [AW-1:0]    addr_reg;
    logic [DATA_W-1:0] val_reg;
    logic [LC-1:0]    i_reg, i_next;
    logic [LC-1:0]    first_reg, first_next, rcnt_reg, rcnt_next;
    logic [LW-1:0]    line_reg, line_next, best_reg, best_next;
    logic             hit_reg, hit_next;
    logic [15:0]      mod_reg, mod_next;
    logic [LC-1:0]    rem_reg, rem_next;
    logic [4:0]       sh_reg, sh_next;
    logic [OC-1:0]    w_reg, w_next;
    logic [MC-1:0]    clr_reg;
    ccc_result_t      res_reg, res_next;
    logic             done_reg, done_next;
    logic [DATA_W-1:0] dout_reg;
    logic             dcap_reg, dcap_next;

    logic [BW-1:0] blk;
    logic [OW-1:0] off;
    logic [LW-1:0] iw;
    logic [3:0]    s_eff;
    logic [RW-1:0] rem_sh;

    logic          dr_we, mr_we;
    logic [DW-1:0] dr_wa, dr_ra;
    logic [DATA_W-1:0] dr_wd, dr_rd, mr_wd, mr_rd;
    logic [MW-1:0] mr_wa, mr_ra;

    // Counter write port driven by the sequencer.
    logic             cw_en;
    logic [LW-1:0]    cw_idx;
    logic [CNT_W-1:0] cw_val;
    logic             dec_en;
    logic             tag_we;
    logic             full_we, full_val, lfsr_we;

    assign blk = BW'(addr_reg[MW-1:0] / BLOCK_WORDS);
    assign off = OW'(addr_reg[MW-1:0] % BLOCK_WORDS);
    assign iw  = i_reg[LW-1:0];
    assign s_eff = (sets_reg == 4'd0) ? 4'd1 :
                   ((32'(sets_reg) > LINES) ? 4'(LINES) : sets_reg);
    assign rem_sh = {rem_reg, mod_reg[15]};

    ccc_ram #(.WIDTH(DATA_W), .DEPTH(LINES * BLOCK_WORDS)) u_data (
        .clk(clk), .we(dr_we), .waddr(dr_wa), .wdata(dr_wd), .raddr(dr_ra), .rdata(dr_rd)
    );

    ccc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_mem (
        .clk(clk), .we(mr_we), .waddr(mr_wa), .wdata(mr_wd), .raddr(mr_ra), .rdata(mr_rd)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg  <= MAP_DIRECT;
            pol_reg  <= POL_LRU;
            wpol_reg <= 1'b0;
            sets_reg <= 4'd2;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAPPING:     map_reg  <= cfg_data[1:0];
                CFG_REPLACEMENT: pol_reg  <= cfg_data[1:0];
                CFG_WRITE:       wpol_reg <= cfg_data[0];
                CFG_SETS:        sets_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            valid_reg <= '0;
            full_reg  <= 1'b0;
            lfsr_reg  <= 16'd1;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            i_reg     <= '0;
            for (int k = 0; k < LINES; k++)
            begin
                tag_reg[k] <= '0;
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            i_reg     <= i_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (dec_en)
            begin
                for (int k = 0; k < LINES; k++)
                begin
                    if (k >= 32'(first_reg) && k < 32'(first_reg) + 32'(rcnt_reg)
                        && cnt_reg[k] != '0 && !(cw_en && k == 32'(cw_idx)))
                    begin
                        cnt_reg[k] <= cnt_reg[k] - 1'b1;
                    end
                end
            end
            if (cw_en)
            begin
                cnt_reg[cw_idx] <= cw_val;
            end
            if (tag_we)
            begin
                tag_reg[line_reg]   <= blk;
                valid_reg[line_reg] <= 1'b1;
            end
            if (full_we)
            begin
                full_reg <= full_val;
            end
            if (lfsr_we)
            begin
                lfsr_reg <= lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            cmd_reg  <= command;
            addr_reg <= AW'(word_address);
            val_reg  <= write_value;
        end
        first_reg <= first_next;
        rcnt_reg  <= rcnt_next;
        line_reg  <= line_next;
        best_reg  <= best_next;
        hit_reg   <= hit_next;
        mod_reg   <= mod_next;
        rem_reg   <= rem_next;
        sh_reg    <= sh_next;
        w_reg     <= w_next;
        res_reg   <= res_next;
        dcap_reg  <= dcap_next;
        if (dcap_reg)
        begin
            dout_reg <= dr_rd;
        end
    end

    logic [CNT_W-1:0] ci, cb;
    logic [CNT_W-1:0] ci_inc;
    assign ci = cnt_reg[iw];
    assign cb = cnt_reg[best_reg];
    assign ci_inc = (ci == CNT_MAX) ? ci : ci + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        first_next = first_reg;
        rcnt_next  = rcnt_reg;
        line_next  = line_reg;
        best_next  = best_reg;
        hit_next   = hit_reg;
        mod_next   = mod_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        w_next     = w_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        dcap_next  = 1'b0;
        cw_en = 1'b0; cw_idx = iw; cw_val = ci_inc;
        dec_en = 1'b0; tag_we = 1'b0;
        full_we = 1'b0; full_val = 1'b0; lfsr_we = 1'b0;
        dr_we = 1'b0; dr_wa = '0; dr_wd = mr_rd; dr_ra = '0;
        mr_we = 1'b0; mr_wa = clr_reg[MW-1:0]; mr_wd = '0; mr_ra = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mr_we = 1'b1;
                if (32'(clr_reg) == MEM_WORDS - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    i_next     = '0;
                    hit_next   = 1'b0;
                    state_next = (32'(word_address) >= MEM_WORDS) ? ST_DONE : ST_LOOKUP;
                    res_next   = '0;
                    res_next.address_error = (32'(word_address) >= MEM_WORDS);
                end
            end
            ST_LOOKUP:
            begin
                if (!hit_next && valid_reg[iw] && tag_reg[iw] == blk)
                begin
                    hit_next  = 1'b1;
                    line_next = iw;
                end
                i_next = i_reg + 1'b1;
                if (32'(i_reg) == LINES - 1)
                begin
                    state_next = ST_RANGE;
                    mod_next   = 16'(blk);
                    i_next     = '0;
                end
            end
            ST_RANGE:
            begin
                // Set range: first = (blk mod S) * (LINES / S), by repeated subtraction.
                if (map_reg == MAP_SET)
                begin
                    if (mod_reg >= 16'(s_eff))
                    begin
                        mod_next = mod_reg - 16'(s_eff);
                    end
                    else if (32'(i_reg) < LINES && (32'(i_reg) + 1) * 32'(s_eff) <= LINES)
                    begin
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        rcnt_next  = i_reg;
                        first_next = LC'(32'(mod_reg) * 32'(i_reg));
                        state_next = ST_PICK;
                    end
                end
                else
                begin
                    first_next = '0;
                    rcnt_next  = LC'(LINES);
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                i_next     = first_reg;
                best_next  = first_reg[LW-1:0];
                if (hit_reg)
                begin
                    line_next = line_reg;
                    if (cmd_reg == CMD_READ && pol_reg == POL_LFU)
                    begin
                        cw_en = 1'b1; cw_idx = line_reg;
                        cw_val = (cnt_reg[line_reg] == CNT_MAX) ? CNT_MAX
                                 : cnt_reg[line_reg] + 1'b1;
                        state_next = ST_WRITE;
                    end
                    else if (cmd_reg == CMD_READ && pol_reg == POL_LRU && map_reg != MAP_DIRECT
                             && map_reg != 2'd3)
                    begin
                        state_next = ST_TOUCH;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
                else if (map_reg != MAP_FULL && map_reg != MAP_SET)
                begin
                    line_next  = LW'(32'(blk) % LINES);
                    state_next = ST_WB_RD;
                    w_next     = '0;
                end
                else if (pol_reg == POL_RANDOM)
                begin
                    lfsr_we  = 1'b1;
                    mod_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);
                    rem_next = '0;
                    sh_next  = '0;
                    state_next = ST_SCAN3;
                end
                else if (pol_reg == POL_FIFO && map_reg == MAP_FULL && full_reg)
                begin
                    state_next = ST_SCAN2;
                end
                else
                begin
                    if (pol_reg == POL_FIFO && map_reg == MAP_FULL)
                    begin
                        full_we = 1'b1; full_val = 1'b1;
                    end
                    state_next = ST_SCAN1;
                end
            end
            ST_SCAN1:
            begin
                // Fifo first scan, LFU minimum search or LRU zero/minimum search.
                if (pol_reg == POL_FIFO)
                begin
                    cw_en = 1'b1;
                    if (ci == '0)
                    begin
                        line_next  = iw;
                        if (map_reg == MAP_FULL)
                        begin
                            full_we = 1'b1; full_val = 1'b0;
                        end
                        state_next = ST_WB_RD;
                        w_next     = '0;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                        if (i_next == first_reg + rcnt_reg)
                        begin
                            i_next = first_reg;
                            state_next = (map_reg == MAP_FULL) ? ST_SCAN2 : ST_SCAN3;
                        end
                    end
                end
                else if (pol_reg == POL_LRU && ci == '0)
                begin
                    cw_en = 1'b1; cw_val = CNT_W'(rcnt_reg);
                    line_next  = iw;
                    state_next = ST_WB_RD;
                    w_next     = '0;
                end
                else
                begin
                    if (ci < cb)
                    begin
                        best_next = iw;
                    end
                    i_next = i_reg + 1'b1;
                    if (i_next == first_reg + rcnt_reg)
                    begin
                        cw_en = 1'b1; cw_idx = best_next;
                        cw_val = (pol_reg == POL_LRU) ? CNT_W'(rcnt_reg) : CNT_W'(1);
                        line_next  = best_next;
                        state_next = ST_WB_RD;
                        w_next     = '0;
                    end
                end
            end
            ST_SCAN2:
            begin
                cw_en = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_next == first_reg + rcnt_reg)
                begin
                    i_next = first_reg;
                    state_next = ST_SCAN3;
                end
            end
            ST_SCAN3:
            begin
                if (pol_reg == POL_RANDOM)
                begin
                    // LFSR mod range size, one dividend bit a cycle, most significant first.
                    mod_next = mod_reg << 1;
                    rem_next = (rem_sh >= RW'(rcnt_reg)) ? LC'(rem_sh - RW'(rcnt_reg))
                               : LC'(rem_sh);
                    sh_next  = sh_reg + 1'b1;
                    if (sh_reg == 5'd15)
                    begin
                        line_next  = LW'(first_reg + rem_next);
                        state_next = ST_WB_RD;
                        w_next     = '0;
                    end
                end
                else
                begin
                    if (ci > cb)
                    begin
                        best_next = iw;
                    end
                    i_next = i_reg + 1'b1;
                    if (i_next == first_reg + rcnt_reg)
                    begin
                        cw_en = 1'b1; cw_idx = best_next; cw_val = CNT_W'(1);
                        line_next  = best_next;
                        state_next = ST_WB_RD;
                        w_next     = '0;
                    end
                end
            end
            ST_TOUCH:
            begin
                dec_en = 1'b1;
                cw_en = 1'b1; cw_idx = line_reg; cw_val = CNT_W'(rcnt_reg);
                state_next = ST_WRITE;
            end
            ST_WB_RD:
            begin
                if (valid_reg[line_reg] && 32'(w_reg) < BLOCK_WORDS)
                begin
                    dr_ra = DW'(32'(line_reg) * BLOCK_WORDS + 32'(w_reg));
                    state_next = ST_WB_WR;
                end
                else
                begin
                    w_next = '0;
                    state_next = ST_FILL_RD;
                end
            end
            ST_WB_WR:
            begin
                mr_we = 1'b1;
                mr_wa = MW'(32'(tag_reg[line_reg]) * BLOCK_WORDS + 32'(w_reg));
                mr_wd = dr_rd;
                w_next = w_reg + 1'b1;
                state_next = ST_WB_RD;
            end
            ST_FILL_RD:
            begin
                if (32'(w_reg) < BLOCK_WORDS)
                begin
                    mr_ra = MW'(32'(blk) * BLOCK_WORDS + 32'(w_reg));
                    state_next = ST_FILL_WR;
                end
                else
                begin
                    tag_we = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_FILL_WR:
            begin
                dr_we = 1'b1;
                dr_wa = DW'(32'(line_reg) * BLOCK_WORDS + 32'(w_reg));
                dr_wd = mr_rd;
                w_next = w_reg + 1'b1;
                state_next = ST_FILL_RD;
            end
            ST_WRITE:
            begin
                if (cmd_reg == CMD_WRITE)
                begin
                    dr_we = 1'b1;
                    dr_wa = DW'(32'(line_reg) * BLOCK_WORDS + 32'(off));
                    dr_wd = val_reg;
                    if (wpol_reg)
                    begin
                        mr_we = 1'b1;
                        mr_wa = addr_reg[MW-1:0];
                        mr_wd = val_reg;
                    end
                end
                state_next = ST_READ;
            end
            ST_READ:
            begin
                dr_ra = DW'(32'(line_reg) * BLOCK_WORDS + 32'(off));
                dcap_next = 1'b1;
                state_next = ST_READ_WAIT;
            end
            ST_READ_WAIT:
            begin
                res_next.hit           = hit_reg;
                res_next.line_index    = LINE_W'(line_reg);
                res_next.block_number  = BLOCK_W'(blk);
                res_next.address_error = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign hit           = res_reg.hit;
    assign line_index    = res_reg.line_index;
    assign block_number  = res_reg.block_number;
    assign address_error = res_reg.address_error;
    assign data_word     = res_reg.address_error ? '0 : dout_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start) |=> busy)
        else $error("command not taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> !address_error)
        else $error("hit on bad address");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the configurable cache controller with a built-in cache predictor.
`timescale 1ns / 1ps

module tb;
    import ccc_pkg::*;

    localparam int NL = LINES_DEF;
    localparam int BW = BLOCK_WORDS_DEF;
    localparam int MB = MEM_BLOCKS_DEF;

    typedef struct packed {
        logic              hit;
        logic [LINE_W-1:0] line_index;
        logic [BLOCK_W-1:0] block_number;
        logic [DATA_W-1:0] data_word;
        logic              address_error;
    } access_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [CMD_W-1:0] command = CMD_READ;
    logic [ADDR_W-1:0] word_address = '0;
    logic signed [DATA_W-1:0] write_value = '0;
    logic done;
    logic hit;
    logic [LINE_W-1:0] line_index;
    logic [BLOCK_W-1:0] block_number;
    logic signed [DATA_W-1:0] data_word;
    logic address_error;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [BLOCK_W-1:0] tag_block [NL];
    bit tag_valid [NL];
    logic [DATA_W-1:0] line_words [NL*BW];
    logic [DATA_W-1:0] mem_words [MB*BW];
    logic [CNT_W-1:0] age [NL];
    bit fifo_wrapped;
    logic [15:0] lfsr;
    logic [1:0] cur_map;
    logic [1:0] cur_pol;
    logic cur_wp;
    logic [3:0] cur_sets;

    access_result_t pending_results [$];
    int mismatches = 0;
    int issued = 0;
    int window_base = 0;

    configurable_cache_controller_top DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .word_address(word_address), .write_value(write_value),
        .done(done), .hit(hit), .line_index(line_index), .block_number(block_number),
        .data_word(data_word), .address_error(address_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void bump_age(int i);
        if (age[i] != CNT_MAX)
            age[i] = age[i] + 1'b1;
    endfunction

    function automatic void set_span(int blk, output int first, output int cnt);
        int s;
        s = cur_sets;
        if (s < 1)
            s = 1;
        if (s > NL)
            s = NL;
        cnt = NL / s;
        first = (blk % s) * cnt;
    endfunction

    function automatic void lru_refresh(int first, int cnt, int ln);
        for (int i = first; i < first + cnt; i++)
            if (age[i] != 0)
                age[i] = age[i] - 1'b1;
        age[ln] = cnt[CNT_W-1:0];
    endfunction

    function automatic int choose_victim(int first, int cnt, bit full);
        int best;
        int last;
        best = first;
        last = first + cnt;
        case (cur_pol)
            POL_RANDOM:
            begin
                if (lfsr[0])
                    lfsr = (lfsr >> 1) ^ LFSR_MASK;
                else
                    lfsr = lfsr >> 1;
                return first + int'(lfsr) % cnt;
            end
            POL_FIFO:
            begin
                if (!full || !fifo_wrapped)
                begin
                    if (full)
                        fifo_wrapped = 1'b1;
                    for (int i = first; i < last; i++)
                    begin
                        if (age[i] == 0)
                        begin
                            bump_age(i);
                            if (full)
                                fifo_wrapped = 1'b0;
                            return i;
                        end
                        bump_age(i);
                    end
                end
                if (full)
                    for (int i = first; i < last; i++)
                        bump_age(i);
                for (int i = first + 1; i < last; i++)
                    if (age[i] > age[best])
                        best = i;
                age[best] = 1;
                return best;
            end
            POL_LFU:
            begin
                for (int i = first + 1; i < last; i++)
                    if (age[i] < age[best])
                        best = i;
                age[best] = 1;
                return best;
            end
            default:
            begin
                for (int i = first; i < last; i++)
                begin
                    if (age[i] == 0)
                    begin
                        age[i] = cnt[CNT_W-1:0];
                        return i;
                    end
                    if (age[i] < age[best])
                        best = i;
                end
                age[best] = cnt[CNT_W-1:0];
                return best;
            end
        endcase
    endfunction

    function automatic access_result_t predict_access(logic cmd, logic [ADDR_W-1:0] addr,
                                                      logic [DATA_W-1:0] val);
        access_result_t r;
        int blk;
        int off;
        int ln;
        int first;
        int cnt;
        bit found;
        r = '0;
        if (int'(addr) >= MB * BW)
        begin
            r.address_error = 1'b1;
            return r;
        end
        blk = addr / BW;
        off = addr % BW;
        found = 1'b0;
        ln = 0;
        for (int i = 0; i < NL; i++)
            if (!found && tag_valid[i] && tag_block[i] == blk)
            begin
                found = 1'b1;
                ln = i;
            end
        if (found)
        begin
            if (cmd == CMD_READ)
            begin
                if (cur_pol == POL_LFU)
                    bump_age(ln);
                else if (cur_pol == POL_LRU)
                begin
                    if (cur_map == MAP_FULL)
                        lru_refresh(0, NL, ln);
                    else if (cur_map == MAP_SET)
                    begin
                        set_span(blk, first, cnt);
                        lru_refresh(first, cnt, ln);
                    end
                end
            end
        end
        else
        begin
            if (cur_map == MAP_FULL)
                ln = choose_victim(0, NL, 1'b1);
            else if (cur_map == MAP_SET)
            begin
                set_span(blk, first, cnt);
                ln = choose_victim(first, cnt, 1'b0);
            end
            else
                ln = blk % NL;
            if (tag_valid[ln] && tag_block[ln] < MB)
                for (int w = 0; w < BW; w++)
                    mem_words[tag_block[ln] * BW + w] = line_words[ln * BW + w];
            for (int w = 0; w < BW; w++)
                line_words[ln * BW + w] = mem_words[blk * BW + w];
            tag_block[ln] = blk[BLOCK_W-1:0];
            tag_valid[ln] = 1'b1;
        end
        if (cmd == CMD_WRITE)
        begin
            line_words[ln * BW + off] = val;
            if (cur_wp)
                mem_words[addr] = val;
        end
        r.hit = found;
        r.line_index = ln[LINE_W-1:0];
        r.block_number = blk[BLOCK_W-1:0];
        r.data_word = line_words[ln * BW + off];
        return r;
    endfunction

    always @(negedge clk)
    begin
        access_result_t exp_r;
        access_result_t got;
        if (rst_n && done)
        begin
            got = '{hit, line_index, block_number, data_word, address_error};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: %p", got);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, actual %p", exp_r, got);
                end
            end
        end
    end

    task automatic issue_access(logic cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] val);
        int idle_pct;
        idle_pct = (issued < 520) ? 11 : (issued < 1040) ? 48 : 0;
        if ($urandom_range(0, 99) < idle_pct)
            repeat ($urandom_range(1, 6)) @(posedge clk);
        @(posedge clk);
        start <= 1'b1;
        command <= cmd;
        word_address <= addr;
        write_value <= val;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        pending_results.push_back(predict_access(cmd, addr, val));
        issued++;
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MAPPING: cur_map = val[1:0];
            CFG_REPLACEMENT: cur_pol = val[1:0];
            CFG_WRITE: cur_wp = val[0];
            CFG_SETS: cur_sets = val;
            default: ;
        endcase
    endtask

    task automatic configure(logic [1:0] map, logic [1:0] pol, logic wp, logic [3:0] sets);
        wait_drained();
        write_register(CFG_MAPPING, {2'b00, map});
        write_register(CFG_REPLACEMENT, {2'b00, pol});
        write_register(CFG_WRITE, {3'b000, wp});
        write_register(CFG_SETS, sets);
    endtask

    task automatic random_burst(int n);
        logic [ADDR_W-1:0] addr;
        int blk;
        window_base = int'($urandom_range(0, MB - 1));
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) < 3)
                addr = ADDR_W'($urandom_range(0, 255));
            else
            begin
                blk = (window_base + int'($urandom_range(0, 11))) % MB;
                addr = ADDR_W'(blk * BW + int'($urandom_range(0, BW - 1)));
            end
            issue_access(1'($urandom_range(0, 1)), addr, $urandom);
            if (k == n / 2)
                wait_drained();
        end
    endtask

    task automatic test_directed_corners();
        issue_access(CMD_READ, 8'd0, 32'd0);
        issue_access(CMD_WRITE, 8'd0, 32'h8000_0000);
        issue_access(CMD_READ, 8'd0, 32'd0);
        issue_access(CMD_WRITE, 8'd255, 32'h7FFF_FFFF);
        issue_access(CMD_READ, 8'd255, 32'hFFFF_FFFF);
        issue_access(CMD_WRITE, 8'd32, 32'hFFFF_FFFF);
        issue_access(CMD_READ, 8'd1, 32'd0);
        issue_access(CMD_READ, 8'd3, 32'd0);
        issue_access(CMD_WRITE, 8'd170, 32'hAAAA_AAAA);
        issue_access(CMD_WRITE, 8'd85, 32'h5555_5555);
        issue_access(CMD_READ, 8'd170, 32'd0);
        issue_access(CMD_READ, 8'd85, 32'd0);
        issue_access(CMD_READ, 8'd224, 32'd0);
        issue_access(CMD_READ, 8'd0, 32'd0);
        issue_access(CMD_READ, 8'd32, 32'd0);
    endtask

    task automatic test_policy_sweep();
        random_burst(110);
        configure(MAP_FULL, POL_RANDOM, 1'b0, 4'd2);
        random_burst(120);
        configure(MAP_FULL, POL_FIFO, 1'b1, 4'd2);
        random_burst(130);
        configure(MAP_FULL, POL_LFU, 1'b0, 4'd2);
        random_burst(120);
        configure(MAP_FULL, POL_LRU, 1'b1, 4'd2);
        random_burst(120);
        configure(MAP_SET, POL_RANDOM, 1'b1, 4'd2);
        random_burst(120);
        configure(MAP_SET, POL_FIFO, 1'b0, 4'd4);
        random_burst(120);
        configure(MAP_SET, POL_LFU, 1'b1, 4'd8);
        random_burst(110);
        configure(MAP_SET, POL_LRU, 1'b0, 4'd1);
        random_burst(120);
        configure(MAP_SET, POL_LRU, 1'b1, 4'd0);
        random_burst(90);
        configure(MAP_SET, POL_FIFO, 1'b1, 4'd15);
        random_burst(90);
        configure(MAP_SET, POL_RANDOM, 1'b0, 4'd3);
        random_burst(110);
        configure(2'd3, POL_LRU, 1'b1, 4'd3);
        random_burst(100);
        configure(MAP_DIRECT, POL_FIFO, 1'b0, 4'd2);
        random_burst(50);
    endtask

    initial
    begin
        for (int i = 0; i < NL; i++)
        begin
            tag_block[i] = '0;
            tag_valid[i] = 1'b0;
            age[i] = '0;
        end
        for (int i = 0; i < NL * BW; i++)
            line_words[i] = '0;
        for (int i = 0; i < MB * BW; i++)
            mem_words[i] = '0;
        fifo_wrapped = 1'b0;
        lfsr = 16'd1;
        cur_map = MAP_DIRECT;
        cur_pol = POL_LRU;
        cur_wp = 1'b0;
        cur_sets = 4'd2;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_corners();
        test_policy_sweep();
        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
